// File: design/bmiod_pkg.sv
// ----------------------------------------------------------------------------
// bmiod_pkg: shared types and codes for the banked memory / io decoder
// Transaction payloads, function codes, status codes and decoder constants.
// ----------------------------------------------------------------------------
package bmiod_pkg;

   // bus function codes
   localparam logic [1:0] FUNC_MEM_READ  = 2'd0;
   localparam logic [1:0] FUNC_MEM_WRITE = 2'd1;
   localparam logic [1:0] FUNC_IO_READ   = 2'd2;
   localparam logic [1:0] FUNC_IO_WRITE  = 2'd3;

   // access status codes
   localparam logic [2:0] ST_MEM_READ  = 3'd0;
   localparam logic [2:0] ST_MEM_WRITE = 3'd1;
   localparam logic [2:0] ST_UNMAPPED  = 3'd2;
   localparam logic [2:0] ST_KEYBOARD  = 3'd3;
   localparam logic [2:0] ST_LATCH     = 3'd4;
   localparam logic [2:0] ST_IO        = 3'd5;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARD_PRESENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LARGE_MODEL  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIRES_KIND   = 2'd2;

   // video mod kinds
   localparam logic [1:0] HIRES_NONE     = 2'd0;
   localparam logic [1:0] HIRES_PORT_32  = 2'd1;
   localparam logic [1:0] HIRES_PORT_222 = 2'd2;

   // io port numbers
   localparam logic [7:0] PORT_BANK     = 8'd55;
   localparam logic [7:0] PORT_COMPAT   = 8'd58;
   localparam logic [7:0] PORT_VIDEO_32 = 8'd32;
   localparam logic [7:0] PORT_VIDEO_222 = 8'd222;

   // address map boundaries
   localparam logic [15:0] ADDR_OVERLAY_LO = 16'h4000;
   localparam logic [15:0] ADDR_LATCH_LO   = 16'h6800;
   localparam logic [15:0] ADDR_LATCH_HI   = 16'h6FFF;
   localparam logic [15:0] ADDR_VIDEO_LO   = 16'h7000;
   localparam logic [15:0] ADDR_VIDEO_END  = 16'h7800;
   localparam logic [15:0] ADDR_TOP_SMALL  = 16'h9000;
   localparam logic [15:0] ADDR_TOP_LARGE  = 16'hB800;

   localparam logic [2:0] MODE_BITS_RESET = 3'b010;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] bus_address;
      logic [7:0]  write_data;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  access_status;
      logic [17:0] phys_address;
      logic [7:0]  row_select;
      logic [7:0]  output_latch;
      logic [2:0]  graphics_mode;
      logic [1:0]  video_bank;
      logic        video_contention;
   } rsp_payload_type;

endpackage

// File: design/banked_memory_io_decoder_core.sv
// ----------------------------------------------------------------------------
// banked_memory_io_decoder_core: cpu bus access decoder with banking
// Maps memory and io transactions onto a 137216-byte store, keyboard row
// strobes and the output latch, and keeps the bank and video registers.
// ----------------------------------------------------------------------------
//
//  channel   ports                               direction  content
//  req       req_valid req_stall req_payload     in         func, address, data
//  rsp       rsp_valid rsp_stall rsp_payload     out        status, map, regs
//  csr       csr_write_enable csr_index csr_...  in         card, model, hires
//
//  one transaction per cycle sustained while rsp is not stalled; rsp valid
//  rises once an accepted req has passed through both registers in turn
//  (input register, then result register)
//  decode and register update happen as a transaction leaves the input
//  register, so a stall on rsp holds both stages and the register state
//  reset is synchronous and active high; it clears both valids and puts the
//  configuration and bank/video/latch registers to their power-up values
//  req_stall rises only when the input register holds a transaction that
//  cannot move into a full, stalled result register
//
module banked_memory_io_decoder_core
   import bmiod_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   // configuration port
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // configuration registers
   logic       card_present_ff;
   logic       large_model_ff;
   logic [1:0] hires_kind_ff;

   // architectural state
   logic [2:0] bank_select_ff, bank_select_in;
   logic       compat_mode_ff, compat_mode_in;
   logic [1:0] vram_bank_ff, vram_bank_in;
   logic [2:0] mode_bits_ff, mode_bits_in;
   logic [7:0] latch_value_ff, latch_value_in;

   // pipeline stages
   logic            s1_valid_ff;
   req_payload_type s1_payload_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic advance;

   // result register frees up when empty or being taken this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ------------------------------------------------------------------
   // decode of the transaction in the input register
   // ------------------------------------------------------------------
   always_comb begin
      logic [15:0] a;
      logic [7:0]  d;
      logic        wr;
      logic        mapped;
      logic [17:0] pa;
      logic [15:0] top;
      logic [1:0]  vb_off;

      a  = s1_payload_ff.bus_address;
      d  = s1_payload_ff.write_data;
      wr = (s1_payload_ff.func == FUNC_MEM_WRITE);

      bank_select_in = bank_select_ff;
      compat_mode_in = compat_mode_ff;
      vram_bank_in   = vram_bank_ff;
      mode_bits_in   = mode_bits_ff;
      latch_value_in = latch_value_ff;

      mapped = 1'b1;
      pa     = {2'b00, a};
      top    = ADDR_TOP_SMALL;
      vb_off = vram_bank_ff - 2'd1;

      rsp_payload_in.access_status    = ST_IO;
      rsp_payload_in.phys_address     = '0;
      rsp_payload_in.row_select       = 8'hFF;
      rsp_payload_in.video_contention = 1'b0;

      // memory map
      if (a < ADDR_OVERLAY_LO) begin
         // fixed rom, writes are dropped
         mapped = !wr;
      end else if (a < ADDR_LATCH_LO) begin
         // rom/ram overlay: reads see rom unless the card banks ram in
         if (!wr && (!card_present_ff || !bank_select_ff[0]))
            pa = {4'b0100, a[13:0]};
         else if (bank_select_ff[1])
            pa = {2'b01, a};
      end else if (a < ADDR_VIDEO_END) begin
         // video window, extra banks live above the second 64k
         if (hires_kind_ff != HIRES_NONE && vram_bank_ff != 2'd0)
            pa = {5'b10000, vb_off, a[10:0]};
      end else if (card_present_ff) begin
         top = compat_mode_ff ? ADDR_TOP_LARGE : ADDR_TOP_SMALL;
         if (a >= top && bank_select_ff[2])
            pa = {2'b01, a};
      end else begin
         top    = large_model_ff ? ADDR_TOP_LARGE : ADDR_TOP_SMALL;
         mapped = (a < top);
      end

      case (s1_payload_ff.func)
         FUNC_MEM_READ, FUNC_MEM_WRITE: begin
            if (a >= ADDR_LATCH_LO && a <= ADDR_LATCH_HI) begin
               if (wr) begin
                  latch_value_in = d;
                  rsp_payload_in.access_status = ST_LATCH;
               end else begin
                  rsp_payload_in.row_select    = a[7:0];
                  rsp_payload_in.access_status = ST_KEYBOARD;
               end
            end else begin
               rsp_payload_in.video_contention =
                  (a >= ADDR_VIDEO_LO) && (a < ADDR_VIDEO_END);
               if (mapped) begin
                  rsp_payload_in.phys_address  = pa;
                  rsp_payload_in.access_status = wr ? ST_MEM_WRITE : ST_MEM_READ;
               end else begin
                  rsp_payload_in.access_status = ST_UNMAPPED;
               end
            end
         end
         FUNC_IO_WRITE: begin
            if (card_present_ff) begin
               if (a[7:0] == PORT_BANK)
                  bank_select_in = d[2:0];
               else if (a[7:0] == PORT_COMPAT)
                  compat_mode_in = d[0];
            end
            if (a[7:0] == PORT_VIDEO_32 && hires_kind_ff == HIRES_PORT_32) begin
               vram_bank_in = d[1:0];
               mode_bits_in = d[4:2];
            end
            if (a[7:0] == PORT_VIDEO_222 && hires_kind_ff == HIRES_PORT_222)
               vram_bank_in = d[1:0];
         end
         default: begin
            // io read: reported, nothing changes
         end
      endcase

      // register view after this transaction
      rsp_payload_in.output_latch  = latch_value_in;
      rsp_payload_in.graphics_mode = mode_bits_in;
      rsp_payload_in.video_bank    = vram_bank_in;
   end

   // ------------------------------------------------------------------
   // control and state registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         card_present_ff <= 1'b0;
         large_model_ff  <= 1'b1;
         hires_kind_ff   <= HIRES_NONE;
         bank_select_ff  <= '0;
         compat_mode_ff  <= 1'b0;
         vram_bank_ff    <= '0;
         mode_bits_ff    <= MODE_BITS_RESET;
         latch_value_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_CARD_PRESENT: card_present_ff <= csr_write_data[0];
               CSR_LARGE_MODEL:  large_model_ff  <= csr_write_data[0];
               CSR_HIRES_KIND:   hires_kind_ff   <= csr_write_data;
               default: begin
                  // unused index, write dropped
               end
            endcase
         end
         if (!req_stall)
            s1_valid_ff <= req_valid;
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               bank_select_ff <= bank_select_in;
               compat_mode_ff <= compat_mode_in;
               vram_bank_ff   <= vram_bank_in;
               mode_bits_ff   <= mode_bits_in;
               latch_value_ff <= latch_value_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid)
         s1_payload_ff <= req_payload;
      if (advance && s1_valid_ff)
         rsp_payload_ff <= rsp_payload_in;
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("req_stall raised with a free pipeline");

   a_rom_write_unmapped: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_payload_ff.func == FUNC_MEM_WRITE &&
       s1_payload_ff.bus_address < ADDR_OVERLAY_LO)
      |=> (rsp_payload_ff.access_status == ST_UNMAPPED))
      else $error("rom write not reported as unmapped");

   a_phys_zero_off_memory: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.access_status != ST_MEM_READ &&
       rsp_payload_ff.access_status != ST_MEM_WRITE)
      |-> (rsp_payload_ff.phys_address == '0))
      else $error("physical address set on a non-memory transaction");

   a_io_read_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_valid_ff && s1_payload_ff.func == FUNC_IO_READ)
      |=> ($stable(bank_select_ff) && $stable(vram_bank_ff) &&
           $stable(mode_bits_ff) && $stable(latch_value_ff)))
      else $error("io read changed decoder state");

endmodule
